// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// Checked on every clock edge, reset included
`define ASSERT_CLK_ALL(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");

`endif

// ----- rtl/arpc_pkg.sv -----
// Shared constants, codes and types of the ARP receive block and address cache
package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int HALF_W  = 16;
    localparam int ENTRY_W = IP_W + MAC_W;
    localparam int CFG_W   = 48;

    // input item layout in s_tdata
    localparam int S_HW_LSB    = 0;
    localparam int S_PROTO_LSB = S_HW_LSB + HALF_W;
    localparam int S_OP_LSB    = S_PROTO_LSB + HALF_W;
    localparam int S_SMAC_LSB  = S_OP_LSB + HALF_W;
    localparam int S_SIP_LSB   = S_SMAC_LSB + MAC_W;
    localparam int S_TIP_LSB   = S_SIP_LSB + IP_W;
    localparam int S_QIP_LSB   = S_TIP_LSB + IP_W;
    localparam int S_TDATA_W   = S_QIP_LSB + IP_W;

    // result item layout in m_tdata
    localparam int M_RMAC_LSB = 0;
    localparam int M_RIP_LSB  = M_RMAC_LSB + MAC_W;
    localparam int M_FMAC_LSB = M_RIP_LSB + IP_W;
    localparam int M_TDATA_W  = M_FMAC_LSB + MAC_W;

    localparam logic [HALF_W-1:0] HW_ETHERNET = 16'h0001;
    localparam logic [HALF_W-1:0] PROTO_IPV4  = 16'h0800;
    localparam logic [HALF_W-1:0] OP_REQUEST  = 16'h0001;
    localparam logic [HALF_W-1:0] OP_REPLY    = 16'h0002;

    localparam logic OPC_PACKET = 1'b0;
    localparam logic OPC_LOOKUP = 1'b1;

    localparam logic REG_OWN_IP = 1'b0;

    typedef enum logic [2:0] {
        ST_DISCARD = 3'd0,
        ST_UPDATED = 3'd1,
        ST_REPLY   = 3'd2,
        ST_HIT     = 3'd3,
        ST_MISS    = 3'd4
    } status_t;

    // write request into the cache
    typedef struct packed {
        logic             en;
        logic             alloc;   // write at the replace pointer and advance it
        logic [IDX_W-1:0] idx;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } cache_wr_t;

    // compare result of the entry read in the previous cycle
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [MAC_W-1:0] mac;
    } cache_cmp_t;

endpackage

// ----- rtl/arpc_cache.sv -----
// Address cache: entry memory, valid bits, replace pointer and the shared IP comparator
module arpc_cache (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [arpc_pkg::IDX_W-1:0]  rd_addr,
    input  logic [arpc_pkg::IP_W-1:0]   key_ip,
    input  arpc_pkg::cache_wr_t         wr,
    output arpc_pkg::cache_cmp_t        cmp
);

    logic [arpc_pkg::ENTRY_W-1:0] mem [arpc_pkg::CACHE_ENTRIES];

    logic [arpc_pkg::CACHE_ENTRIES-1:0] valid_reg;
    logic [arpc_pkg::IDX_W-1:0]         ptr_reg;
    logic [arpc_pkg::IDX_W-1:0]         ptr_next;
    logic                               rd_vld_reg;
    logic [arpc_pkg::IDX_W-1:0]         rd_idx_reg;
    logic                               rd_valid_bit_reg;
    logic [arpc_pkg::ENTRY_W-1:0]       rd_data_reg;
    logic [arpc_pkg::IDX_W-1:0]         wr_addr;
    logic [arpc_pkg::IP_W-1:0]          rd_ip;

    assign wr_addr = wr.alloc ? ptr_reg : wr.idx;

    always_comb begin
        if (ptr_reg == arpc_pkg::IDX_W'(arpc_pkg::CACHE_ENTRIES - 1)) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= {wr.ip, wr.mac};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= '0;
            ptr_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            rd_idx_reg       <= '0;
            rd_valid_bit_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            if (rd_en) begin
                rd_idx_reg       <= rd_addr;
                rd_valid_bit_reg <= valid_reg[rd_addr];
            end
            if (wr.en && wr.alloc) begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= ptr_next;
            end
        end
    end

    assign rd_ip = rd_data_reg[arpc_pkg::ENTRY_W-1 -: arpc_pkg::IP_W];

    always_comb begin
        cmp.hit = rd_vld_reg && rd_valid_bit_reg && (rd_ip == key_ip);
        cmp.idx = rd_idx_reg;
        cmp.mac = rd_data_reg[arpc_pkg::MAC_W-1:0];
    end

endmodule

// ----- rtl/arp_receive_with_address_cache.sv -----
// ARP receive block: packet filter, request reply and round-robin IPv4-to-MAC cache.
// Discarded packets and requests: status registered on acceptance, then output from S_DONE.
// Replies and lookups: linear search one entry a cycle through the single cache read
// port, then the result is output from S_DONE.
// One item at a time: s_tready is high only while idle, until the last result is output.
// Reset (synchronous, aresetn low) clears valid bits, replace pointer, own_ip and output.
module arp_receive_with_address_cache (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [arpc_pkg::CFG_W-1:0]      cfg_wdata,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // hw type, proto type, arp_operation, sender_mac, sender_ip, target_ip, query_ip
    input  logic [arpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic [0:0]                      s_tuser,
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // reply_mac, reply_ip, found_mac
    output logic [arpc_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [2:0]                      m_tuser
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                          state_reg;
    logic                            lookup_reg;
    logic [arpc_pkg::IP_W-1:0]       key_ip_reg;
    logic [arpc_pkg::MAC_W-1:0]      smac_reg;
    logic [arpc_pkg::CNT_W-1:0]      scan_cnt_reg;
    arpc_pkg::status_t               res_status_reg;
    logic [arpc_pkg::MAC_W-1:0]      res_rmac_reg;
    logic [arpc_pkg::IP_W-1:0]       res_rip_reg;
    logic [arpc_pkg::MAC_W-1:0]      res_fmac_reg;
    logic [arpc_pkg::IP_W-1:0]       own_ip_reg;
    logic                            m_tvalid_reg;
    logic [arpc_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic [2:0]                      m_tuser_reg;

    logic [arpc_pkg::HALF_W-1:0]     in_hw;
    logic [arpc_pkg::HALF_W-1:0]     in_proto;
    logic [arpc_pkg::HALF_W-1:0]     in_op;
    logic [arpc_pkg::MAC_W-1:0]      in_smac;
    logic [arpc_pkg::IP_W-1:0]       in_sip;
    logic [arpc_pkg::IP_W-1:0]       in_tip;
    logic [arpc_pkg::IP_W-1:0]       in_qip;
    logic                            pkt_ok;
    logic                            s_accept;
    logic                            scan_last;
    logic                            scan_done;
    logic                            out_load;
    logic                            rd_en;
    arpc_pkg::cache_wr_t             wr;
    arpc_pkg::cache_cmp_t            cmp;

    assign in_hw    = s_tdata[arpc_pkg::S_HW_LSB    +: arpc_pkg::HALF_W];
    assign in_proto = s_tdata[arpc_pkg::S_PROTO_LSB +: arpc_pkg::HALF_W];
    assign in_op    = s_tdata[arpc_pkg::S_OP_LSB    +: arpc_pkg::HALF_W];
    assign in_smac  = s_tdata[arpc_pkg::S_SMAC_LSB  +: arpc_pkg::MAC_W];
    assign in_sip   = s_tdata[arpc_pkg::S_SIP_LSB   +: arpc_pkg::IP_W];
    assign in_tip   = s_tdata[arpc_pkg::S_TIP_LSB   +: arpc_pkg::IP_W];
    assign in_qip   = s_tdata[arpc_pkg::S_QIP_LSB   +: arpc_pkg::IP_W];

    assign pkt_ok = (in_hw == arpc_pkg::HW_ETHERNET) && (in_proto == arpc_pkg::PROTO_IPV4)
                    && (in_tip == own_ip_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // all entries have been read once scan_cnt reaches the depth
    assign scan_last = (scan_cnt_reg == arpc_pkg::CNT_W'(arpc_pkg::CACHE_ENTRIES));
    assign scan_done = (state_reg == S_SCAN) && (cmp.hit || scan_last);
    assign rd_en     = (state_reg == S_SCAN) && !scan_last;
    assign out_load  = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        wr.en    = scan_done && !lookup_reg;
        wr.alloc = !cmp.hit;
        wr.idx   = cmp.idx;
        wr.ip    = key_ip_reg;
        wr.mac   = smac_reg;
    end

    arpc_cache u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (scan_cnt_reg[arpc_pkg::IDX_W-1:0]),
        .key_ip  (key_ip_reg),
        .wr      (wr),
        .cmp     (cmp)
    );

    // own_mac is accepted on the port but enters no result, so it is not stored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg <= '0;
        end else if (cfg_wr_en && (cfg_index == arpc_pkg::REG_OWN_IP)) begin
            own_ip_reg <= cfg_wdata[arpc_pkg::IP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            lookup_reg     <= 1'b0;
            res_status_reg <= arpc_pkg::ST_DISCARD;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        lookup_reg   <= s_tuser[0];
                        smac_reg     <= in_smac;
                        scan_cnt_reg <= '0;
                        res_rmac_reg <= '0;
                        res_rip_reg  <= '0;
                        res_fmac_reg <= '0;
                        if (s_tuser[0] == arpc_pkg::OPC_LOOKUP) begin
                            key_ip_reg <= in_qip;
                            state_reg  <= S_SCAN;
                        end else if (pkt_ok && (in_op == arpc_pkg::OP_REPLY)) begin
                            key_ip_reg <= in_sip;
                            state_reg  <= S_SCAN;
                        end else if (pkt_ok && (in_op == arpc_pkg::OP_REQUEST)) begin
                            res_status_reg <= arpc_pkg::ST_REPLY;
                            res_rmac_reg   <= in_smac;
                            res_rip_reg    <= in_sip;
                            state_reg      <= S_DONE;
                        end else begin
                            res_status_reg <= arpc_pkg::ST_DISCARD;
                            state_reg      <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (!scan_last) begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    if (scan_done) begin
                        state_reg <= S_DONE;
                        if (lookup_reg == arpc_pkg::OPC_LOOKUP) begin
                            if (cmp.hit) begin
                                res_status_reg <= arpc_pkg::ST_HIT;
                                res_fmac_reg   <= cmp.mac;
                            end else begin
                                res_status_reg <= arpc_pkg::ST_MISS;
                            end
                        end else begin
                            res_status_reg <= arpc_pkg::ST_UPDATED;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tuser_reg  <= res_status_reg;
                m_tdata_reg  <= {res_fmac_reg, res_rip_reg, res_rmac_reg};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/arpc_checker.sv -----
// Port-level checker for the ARP receive block, bound to the top level
`include "assert_macros.svh"

module arpc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [arpc_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [2:0]                      m_tuser
);

    logic m_stall;
    logic reply_ok;
    logic found_ok;

    assign m_stall  = m_tvalid && !m_tready;
    assign reply_ok = (m_tuser == arpc_pkg::ST_REPLY)
                      || (m_tdata[arpc_pkg::M_FMAC_LSB-1:0] == '0);
    assign found_ok = (m_tuser == arpc_pkg::ST_HIT)
                      || (m_tdata[arpc_pkg::M_TDATA_W-1:arpc_pkg::M_FMAC_LSB] == '0);

    // a stalled result stays and holds its payload
    `ASSERT_CLK(a_out_hold, m_stall |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

    // one request at a time: no acceptance right after one
    `ASSERT_CLK(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready)

    // reply fields are zero unless a reply is asked for, found_mac zero unless a hit
    `ASSERT_CLK(a_zero_fields, m_tvalid |-> (reply_ok && found_ok))

    // reset leaves no result pending
    `ASSERT_CLK_ALL(a_reset_empty, !aresetn |=> !m_tvalid)

endmodule

bind arp_receive_with_address_cache arpc_checker u_arpc_checker (.*);
